// ----- rtl/bdeq_pkg.sv -----
// shared constants, codes and types for the bounded double-ended queue
package bdeq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned FILL_W = 5;

  // stream word widths, padded to whole bytes
  localparam int unsigned IN_RAW_W   = OP_W + DATA_W;
  localparam int unsigned OUT_RAW_W  = DATA_W + STS_W + FILL_W;
  localparam int unsigned IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

  // status codes
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic latch_in;  // capture the input word
    logic exec;      // run the operation on ring and pointers
    logic load_out;  // move the result into the output register
  } bdeq_cmd_t;

endpackage

// ----- rtl/bdeq_ctrl.sv -----
// controller: sequences accept, execute and result load, owns the stream handshakes
module bdeq_ctrl
  import bdeq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  output bdeq_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // output register can take a new word if empty or drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q;
    cmd_o          = '0;
    s_axis_tready  = 1'b0;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/bdeq_datapath.sv -----
// datapath: ring storage, front pointer, occupancy and result register
module bdeq_datapath
  import bdeq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bdeq_cmd_t              cmd_i,
  input  logic [IN_TDATA_W-1:0]  in_word_i,
  output logic [OUT_TDATA_W-1:0] out_word_o
);

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];

  logic [OP_W-1:0]        op_q;
  logic [DATA_W-1:0]      value_q;
  logic [IDX_W-1:0]       front_q, front_d;
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic [STS_W-1:0]       status_q, status_d;
  logic                   pop_ok_q, pop_ok_d;
  logic [FILL_W-1:0]      fill_q;
  logic [DATA_W-1:0]      rd_q;
  logic [OUT_TDATA_W-1:0] out_q;

  logic             empty, full;
  logic [IDX_W-1:0] occ_idx;
  logic [IDX_W-1:0] slot;
  logic             wr_en, rd_en;
  logic [DATA_W-1:0] pop_value;

  assign empty   = (occ_q == '0);
  assign full    = (occ_q == OCC_W'(DEPTH));
  assign occ_idx = occ_q[IDX_W-1:0];

  always_comb begin
    front_d  = front_q;
    occ_d    = occ_q;
    status_d = ST_OK;
    pop_ok_d = 1'b0;
    slot     = front_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    unique case (op_q)
      OP_PUSH_FRONT: begin
        slot = ring_add(front_q, IDX_W'(DEPTH - 1));
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          front_d = slot;
          occ_d   = occ_q + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        slot = ring_add(front_q, occ_idx);
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en = 1'b1;
          occ_d = occ_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        slot = front_q;
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          pop_ok_d = 1'b1;
          front_d  = ring_add(front_q, IDX_W'(1));
          occ_d    = occ_q - 1'b1;
        end
      end
      OP_POP_BACK: begin
        slot = ring_add(front_q, occ_idx - 1'b1);
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          pop_ok_d = 1'b1;
          occ_d    = occ_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // ring memory, one access per operation, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[slot] <= value_q;
    end
    if (cmd_i.exec && rd_en) begin
      rd_q <= mem[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      occ_q   <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q    <= in_word_i[OP_W-1:0];
      value_q <= in_word_i[OP_W +: DATA_W];
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
      fill_q   <= FILL_W'(occ_d);
    end
    if (cmd_i.load_out) begin
      out_q <= OUT_TDATA_W'({fill_q, status_q, pop_value});
    end
  end

  assign pop_value  = pop_ok_q ? rd_q : '0;
  assign out_word_o = out_q;

endmodule

// ----- rtl/bounded_double_ended_queue_unit.sv -----
// top level of the bounded double-ended queue
//
// Fixed-depth double-ended queue of signed 32-bit values held in a ring of
// DEPTH entries (16). Every input word carries one operation (push front,
// push back, pop front, pop back) and produces exactly one output word with
// the popped value, a status code and the fill level after the operation.
// A pop from an empty queue reports status empty and leaves the queue as it
// is; a push to a full queue drops the value and reports status full; in
// both cases and for every push the popped value is zero. Each word passes
// through three steps: accept, the single ring memory access and pointer
// update, and the load of the output register, which waits while that
// register holds an unread result; no new word is taken before the last is
// loaded. The output register decouples the two sides, so the next word is
// accepted while the previous result waits for m_axis_tready. The ring needs
// no clearing after reset: a pop only reads slots written by an earlier push.
module bounded_double_ended_queue_unit
  import bdeq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input word stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // op[1:0], push_value[33:2], zero pad
  // result word stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // pop_value[31:0], status[33:32],
                                                // fill_level[38:34], zero pad
);

  bdeq_cmd_t cmd;

  // controller: handshakes and sequencing
  bdeq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  // datapath: ring, pointers and result register
  bdeq_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (s_axis_tdata),
    .out_word_o (m_axis_tdata)
  );

endmodule

// ----- rtl/bdeq_checker.sv -----
// port-level checker for the bounded double-ended queue, bound to the top level
module bdeq_checker
  import bdeq_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [DATA_W-1:0] pop_value;
  logic [STS_W-1:0]  status;
  logic [FILL_W-1:0] fill_level;

  assign pop_value  = m_axis_tdata[DATA_W-1:0];
  assign status     = m_axis_tdata[DATA_W +: STS_W];
  assign fill_level = m_axis_tdata[DATA_W + STS_W +: FILL_W];

  // stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word withdrawn while stalled");

  // no status code beyond full
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
    else $error("undefined status code");

  // an empty pop leaves nothing held and returns zero
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ST_EMPTY |-> fill_level == '0 && pop_value == '0)
    else $error("empty pop result inconsistent");

  // a refused push only happens at full depth
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ST_FULL |-> fill_level == FILL_W'(DEPTH) && pop_value == '0)
    else $error("full push result inconsistent");

  // one word in flight: no input accepted in the cycle after an accept
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted back to back");

endmodule

bind bounded_double_ended_queue_unit bdeq_checker u_bdeq_checker (.*);
